/* rtl/lce_pkg.sv */
package lce_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int CNT_W = 5;
	localparam int SIZE_W = 32;
	localparam int STAMP_W = 32;
	localparam int BYTES_W = 36;

	typedef enum logic [1:0] {
		OP_ACCESS = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_PIN    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_HIT      = 3'd0,
		K_INSERTED = 3'd1,
		K_EVICTED  = 3'd2,
		K_REMOVED  = 3'd3,
		K_NOTFOUND = 3'd4,
		K_FULL     = 3'd5,
		K_DONE     = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_ESCAN,
		ST_EDEC,
		ST_EMIT,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] key;
		logic [31:0] size_bytes;
		logic        pin;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] out_key;
		logic [31:0] out_size;
		logic [4:0]  entry_count;
		logic [35:0] resident_bytes;
		logic        last;
	} out_word_t;

	// command from sequencer to every cell
	typedef struct packed {
		logic scan;     // shift scan token down the chain
		logic start;    // load first scan token
		logic clear;    // drop all entries
		logic write;    // write the selected slot
		logic inval;    // invalidate selected slot
		logic set_pin;  // replace pin of selected slot
		logic stamp;    // refresh stamp of selected slot
	} cell_cmd_t;

endpackage

/* rtl/lce_cell.sv */
// One directory slot. Scan records travel from cell i to cell i+1 each cycle.
module lce_cell #(
	parameter int KW = 32,
	parameter int IW = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IW-1:0]          idx,
	input  lce_pkg::cell_cmd_t     cmd,
	input  logic [IW-1:0]          sel,
	input  logic [KW-1:0]          wr_key,
	input  logic [31:0]            wr_size,
	input  logic [31:0]            wr_stamp,
	input  logic                   wr_pin,
	input  logic [KW-1:0]          find_key,
	input  logic [31:0]            counter,
	// scan record in from previous cell
	input  logic                   tok_i,
	input  logic                   hit_i,
	input  logic [IW-1:0]          hit_idx_i,
	input  logic                   free_i,
	input  logic [IW-1:0]          free_idx_i,
	input  logic                   old_i,
	input  logic [IW-1:0]          old_idx_i,
	input  logic [31:0]            old_age_i,
	input  logic [4:0]             cnt_i,
	output logic                   tok_o,
	output logic                   hit_o,
	output logic [IW-1:0]          hit_idx_o,
	output logic                   free_o,
	output logic [IW-1:0]          free_idx_o,
	output logic                   old_o,
	output logic [IW-1:0]          old_idx_o,
	output logic [31:0]            old_age_o,
	output logic [4:0]             cnt_o,
	output logic [KW-1:0]          key_o,
	output logic [31:0]            size_o,
	output logic                   pin_o
);
	import lce_pkg::*;

	logic          valid_q;
	logic [KW-1:0] key_q;
	logic [31:0]   size_q;
	logic [31:0]   stamp_q;
	logic          pin_q;
	logic [31:0]   age;
	logic          me;

	assign me = (sel == idx);
	assign age = counter - stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (me && cmd.write) begin
			valid_q <= 1'b1;
		end else if (me && cmd.inval) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (me && cmd.write) begin
			key_q   <= wr_key;
			size_q  <= wr_size;
			pin_q   <= wr_pin;
		end
		if (me && (cmd.write || cmd.stamp)) begin
			stamp_q <= wr_stamp;
		end
		if (me && cmd.set_pin) begin
			pin_q <= wr_pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_o <= 1'b0;
		end else begin
			tok_o <= cmd.scan & (cmd.start | tok_i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hit_o      <= valid_q && (key_q == find_key);
			hit_idx_o  <= idx;
			free_o     <= !valid_q;
			free_idx_o <= idx;
			old_o      <= valid_q;
			old_idx_o  <= idx;
			old_age_o  <= age;
			cnt_o      <= {4'd0, valid_q};
		end else begin
			hit_o      <= hit_i || (valid_q && (key_q == find_key));
			hit_idx_o  <= hit_i ? hit_idx_i : idx;
			free_o     <= free_i || !valid_q;
			free_idx_o <= free_i ? free_idx_i : idx;
			if (valid_q && (!old_i || age > old_age_i)) begin
				old_o     <= 1'b1;
				old_idx_o <= idx;
				old_age_o <= age;
			end else begin
				old_o     <= old_i;
				old_idx_o <= old_idx_i;
				old_age_o <= old_age_i;
			end
			cnt_o <= cnt_i + {4'd0, valid_q};
		end
	end

	assign key_o  = key_q;
	assign size_o = size_q;
	assign pin_o  = pin_q;

endmodule

/* rtl/lru_cache_evictor_with_byte_budget.sv */
// LRU directory with byte budget and pinning. Each operation but clear runs
// a scan through a chain of ENTRIES cells; an access then scans again for
// each eviction while over budget, and stops at a pinned oldest entry.
// Output stalls hold the sequencer. One result word per eviction, then a
// final status word with last set. The next input word is taken once the
// final word is registered for output. Registers: 0 max_entries, 4 max_bytes
// (APB, selected by paddr[2]).
module lru_cache_evictor_with_byte_budget #(
	parameter int ENTRIES = lce_pkg::ENTRIES_DEF,
	parameter int KEY_WIDTH = lce_pkg::KEY_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lce_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output lce_pkg::out_word_t  out_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import lce_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int SCAN_W = $clog2(ENTRIES + 2);

	state_t state_q, state_d;
	in_word_t req_q;
	logic [4:0] max_entries_q;
	logic [31:0] max_bytes_q;
	logic [31:0] counter_q;
	logic [35:0] bytes_q;
	logic [SCAN_W-1:0] scan_q;
	kind_t fkind_q;
	logic [31:0] fsize_q;
	logic [31:0] ekey_q, esize_q;
	logic [IW-1:0] eidx_q;
	cell_cmd_t cmd;
	logic [IW-1:0] sel;
	logic [31:0] wr_stamp;

	logic          tok   [ENTRIES+1];
	logic          hit   [ENTRIES+1];
	logic [IW-1:0] hidx  [ENTRIES+1];
	logic          fre   [ENTRIES+1];
	logic [IW-1:0] fidx  [ENTRIES+1];
	logic          old   [ENTRIES+1];
	logic [IW-1:0] oidx  [ENTRIES+1];
	logic [31:0]   oage  [ENTRIES+1];
	logic [4:0]    cnt   [ENTRIES+1];
	logic [KEY_WIDTH-1:0] ckey [ENTRIES];
	logic [31:0]   csize [ENTRIES];
	logic          cpin  [ENTRIES];

	assign tok[0] = 1'b0;
	assign hit[0] = 1'b0;
	assign hidx[0] = '0;
	assign fre[0] = 1'b0;
	assign fidx[0] = '0;
	assign old[0] = 1'b0;
	assign oidx[0] = '0;
	assign oage[0] = '0;
	assign cnt[0] = '0;

	logic [KEY_WIDTH-1:0] fkey;
	assign fkey = KEY_WIDTH'(req_q.key);

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			lce_cell #(.KW(KEY_WIDTH), .IW(IW)) u_cell (
				.clk(clk), .arst_n(arst_n), .idx(IW'(g)), .cmd(cmd), .sel(sel),
				.wr_key(fkey), .wr_size(req_q.size_bytes), .wr_stamp(wr_stamp),
				.wr_pin(req_q.pin), .find_key(fkey), .counter(counter_q),
				.tok_i(tok[g]), .hit_i(hit[g]), .hit_idx_i(hidx[g]),
				.free_i(fre[g]), .free_idx_i(fidx[g]), .old_i(old[g]),
				.old_idx_i(oidx[g]), .old_age_i(oage[g]), .cnt_i(cnt[g]),
				.tok_o(tok[g+1]), .hit_o(hit[g+1]), .hit_idx_o(hidx[g+1]),
				.free_o(fre[g+1]), .free_idx_o(fidx[g+1]), .old_o(old[g+1]),
				.old_idx_o(oidx[g+1]), .old_age_o(oage[g+1]), .cnt_o(cnt[g+1]),
				.key_o(ckey[g]), .size_o(csize[g]), .pin_o(cpin[g])
			);
		end
	endgenerate

	// chain result after the last cell
	logic e_hit, e_free, e_old;
	logic [IW-1:0] e_hidx, e_fidx, e_oidx;
	assign e_hit = hit[ENTRIES];
	assign e_free = fre[ENTRIES];
	assign e_old = old[ENTRIES];
	assign e_hidx = hidx[ENTRIES];
	assign e_fidx = fidx[ENTRIES];
	assign e_oidx = oidx[ENTRIES];

	logic scan_done;
	assign scan_done = (scan_q == SCAN_W'(ENTRIES));

	// resident count tracked directly
	logic [CW-1:0] rcount_q;
	logic over;
	assign over = ((max_entries_q != 5'd0) && ({{(32-CW){1'b0}}, rcount_q} >
		{27'd0, max_entries_q})) ||
		((max_bytes_q != 32'd0) && (bytes_q > {4'd0, max_bytes_q}));

	logic out_free;
	assign out_free = !out_valid || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = (in_word.opcode == OP_CLEAR) ? ST_FINAL : ST_SCAN;
			ST_SCAN: if (scan_done) state_d = ST_APPLY;
			ST_APPLY: begin
				if (req_q.opcode == OP_ACCESS) state_d = ST_EDEC;
				else state_d = ST_FINAL;
			end
			ST_EDEC: begin
				if ((max_entries_q == 5'd0 && max_bytes_q == 32'd0) || rcount_q == '0 || !over)
					state_d = ST_FINAL;
				else state_d = ST_ESCAN;
			end
			ST_ESCAN: begin
				if (scan_done) begin
					if (cpin[e_oidx] || !e_old) state_d = ST_FINAL;
					else state_d = ST_EMIT;
				end
			end
			ST_EMIT: if (out_free) state_d = ST_EDEC;
			ST_FINAL: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// cell commands
	always_comb begin
		cmd = '0;
		sel = e_hidx;
		wr_stamp = counter_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.clear = in_valid && (in_word.opcode == OP_CLEAR);
			end
			ST_SCAN, ST_ESCAN: begin
				cmd.scan = !scan_done;
				cmd.start = (scan_q == '0);
			end
			ST_APPLY: begin
				unique case (req_q.opcode)
					OP_ACCESS: begin
						if (e_hit) cmd.stamp = 1'b1;
						else if (e_free) begin
							cmd.write = 1'b1;
							sel = e_fidx;
						end
					end
					OP_REMOVE: cmd.inval = e_hit;
					OP_PIN: cmd.set_pin = e_hit;
					default: ;
				endcase
			end
			ST_EMIT: begin
				sel = eidx_q;
				cmd.inval = out_free;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			counter_q <= '0;
			bytes_q <= '0;
			rcount_q <= '0;
			scan_q <= '0;
			out_valid <= 1'b0;
			max_entries_q <= '0;
			max_bytes_q <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite) begin
				if (paddr[2] == 1'b0) max_entries_q <= pwdata[4:0];
				else max_bytes_q <= pwdata;
			end
			if ((state_q == ST_EMIT || state_q == ST_FINAL) && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (state_q == ST_SCAN || state_q == ST_ESCAN)
				scan_q <= scan_done ? '0 : scan_q + 1'b1;
			if (state_q == ST_IDLE && in_valid && in_word.opcode == OP_CLEAR) begin
				bytes_q <= '0;
				rcount_q <= '0;
			end
			if (state_q == ST_APPLY) begin
				unique case (req_q.opcode)
					OP_ACCESS: begin
						if (e_hit || e_free) counter_q <= counter_q + 1'b1;
						if (!e_hit && e_free) begin
							bytes_q <= bytes_q + {4'd0, req_q.size_bytes};
							rcount_q <= rcount_q + 1'b1;
						end
					end
					OP_REMOVE: if (e_hit) begin
						bytes_q <= bytes_q - {4'd0, csize[e_hidx]};
						rcount_q <= rcount_q - 1'b1;
					end
					default: ;
				endcase
			end
			if (state_q == ST_EMIT && out_free) begin
				bytes_q <= bytes_q - {4'd0, esize_q};
				rcount_q <= rcount_q - 1'b1;
			end
		end
	end

	logic [35:0] bytes_after;
	assign bytes_after = bytes_q - {4'd0, esize_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) req_q <= in_word;
		if (state_q == ST_IDLE && in_valid && in_word.opcode == OP_CLEAR) begin
			fkind_q <= K_DONE;
			fsize_q <= '0;
		end
		if (state_q == ST_APPLY) begin
			unique case (req_q.opcode)
				OP_ACCESS: begin
					fkind_q <= e_hit ? K_HIT : (e_free ? K_INSERTED : K_FULL);
					fsize_q <= e_hit ? csize[e_hidx] : req_q.size_bytes;
				end
				OP_REMOVE: begin
					fkind_q <= e_hit ? K_REMOVED : K_NOTFOUND;
					fsize_q <= e_hit ? csize[e_hidx] : '0;
				end
				OP_PIN: begin
					fkind_q <= e_hit ? K_HIT : K_NOTFOUND;
					fsize_q <= e_hit ? csize[e_hidx] : '0;
				end
				default: ;
			endcase
		end
		if (state_q == ST_ESCAN && scan_done) begin
			eidx_q <= e_oidx;
			ekey_q <= 32'(ckey[e_oidx]);
			esize_q <= csize[e_oidx];
		end
		if (state_q == ST_EMIT && out_free) begin
			out_word.kind <= K_EVICTED;
			out_word.out_key <= ekey_q;
			out_word.out_size <= esize_q;
			out_word.entry_count <= 5'(rcount_q - 1'b1);
			out_word.resident_bytes <= bytes_after;
			out_word.last <= 1'b0;
		end
		if (state_q == ST_FINAL && out_free) begin
			out_word.kind <= fkind_q;
			out_word.out_key <= (fkind_q == K_DONE) ? '0 : req_q.key;
			out_word.out_size <= fsize_q;
			out_word.entry_count <= 5'(rcount_q);
			out_word.resident_bytes <= bytes_q;
			out_word.last <= 1'b1;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {27'd0, max_entries_q} : max_bytes_q;

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= CW'(ENTRIES)) else $error("count overflow");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output dropped");

endmodule

/* bench/tb_top.sv */
module tb_top;
	import lce_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	localparam logic [2:0] ADDR_MAX_ENTRIES = 3'd0;
	localparam logic [2:0] ADDR_MAX_BYTES = 3'd4;

	lru_cache_evictor_with_byte_budget dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	class lru_scoreboard;
		bit s_valid[16];
		bit [31:0] s_key[16];
		bit [31:0] s_size[16];
		bit [31:0] s_stamp[16];
		bit s_pin[16];
		bit [31:0] counter;
		bit [35:0] total;
		bit [4:0] lim_entries;
		bit [31:0] lim_bytes;
		out_word_t pending[$];
		int errors;

		function void reset_state();
			foreach (s_valid[i]) s_valid[i] = 0;
			counter = 0;
			total = 0;
			lim_entries = 0;
			lim_bytes = 0;
			pending.delete();
			errors = 0;
		endfunction

		function bit [4:0] live();
			bit [4:0] c;
			c = 0;
			foreach (s_valid[i]) if (s_valid[i]) c++;
			return c;
		endfunction

		function void push(kind_t k, bit [31:0] key, bit [31:0] size);
			out_word_t w;
			w.kind = k;
			w.out_key = key;
			w.out_size = size;
			w.entry_count = live();
			w.resident_bytes = total;
			w.last = 0;
			pending.push_back(w);
		endfunction

		function int find(bit [31:0] key);
			foreach (s_valid[i]) if (s_valid[i] && s_key[i] == key) return i;
			return -1;
		endfunction

		function void evict_lru();
			int old;
			bit [31:0] best;
			bit [31:0] age;
			bit over_c;
			bit over_b;
			if (lim_entries == 0 && lim_bytes == 0) return;
			forever begin
				if (live() == 0) break;
				over_c = lim_entries != 0 && live() > lim_entries;
				over_b = lim_bytes != 0 && total > {4'd0, lim_bytes};
				if (!over_c && !over_b) break;
				old = -1;
				best = 0;
				foreach (s_valid[i]) begin
					if (s_valid[i]) begin
						age = counter - s_stamp[i];
						if (old < 0 || age > best) begin
							old = i;
							best = age;
						end
					end
				end
				if (old < 0 || s_pin[old]) break;
				s_valid[old] = 0;
				total -= s_size[old];
				push(K_EVICTED, s_key[old], s_size[old]);
			end
		endfunction

		function void note_input(in_word_t w);
			int s;
			kind_t k;
			bit [31:0] rsize;
			out_word_t t;
			case (op_t'(w.opcode))
				OP_ACCESS: begin
					s = find(w.key);
					rsize = w.size_bytes;
					if (s >= 0) begin
						s_stamp[s] = counter;
						counter++;
						k = K_HIT;
						rsize = s_size[s];
					end else begin
						s = -1;
						for (int i = 0; i < 16; i++)
							if (!s_valid[i] && s < 0) s = i;
						if (s < 0) k = K_FULL;
						else begin
							s_valid[s] = 1;
							s_key[s] = w.key;
							s_size[s] = w.size_bytes;
							s_stamp[s] = counter;
							s_pin[s] = w.pin;
							counter++;
							total += w.size_bytes;
							k = K_INSERTED;
						end
					end
					evict_lru();
					push(k, w.key, rsize);
				end
				OP_REMOVE: begin
					s = find(w.key);
					if (s >= 0) begin
						s_valid[s] = 0;
						total -= s_size[s];
						push(K_REMOVED, w.key, s_size[s]);
					end else push(K_NOTFOUND, w.key, 0);
				end
				OP_CLEAR: begin
					foreach (s_valid[i]) s_valid[i] = 0;
					total = 0;
					push(K_DONE, 0, 0);
				end
				default: begin
					s = find(w.key);
					if (s >= 0) begin
						s_pin[s] = w.pin;
						push(K_HIT, w.key, s_size[s]);
					end else push(K_NOTFOUND, w.key, 0);
				end
			endcase
			t = pending.pop_back();
			t.last = 1;
			pending.push_back(t);
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.kind !== exp.kind) begin
				$display("%0t: kind exp %0d got %0d", $time, exp.kind, got.kind);
				errors++;
			end
			if (got.out_key !== exp.out_key) begin
				$display("%0t: key exp %h got %h", $time, exp.out_key, got.out_key);
				errors++;
			end
			if (got.out_size !== exp.out_size) begin
				$display("%0t: size exp %h got %h", $time, exp.out_size, got.out_size);
				errors++;
			end
			if (got.entry_count !== exp.entry_count) begin
				$display("%0t: count exp %0d got %0d", $time, exp.entry_count,
					got.entry_count);
				errors++;
			end
			if (got.resident_bytes !== exp.resident_bytes) begin
				$display("%0t: bytes exp %h got %h", $time, exp.resident_bytes,
					got.resident_bytes);
				errors++;
			end
			if (got.last !== exp.last) begin
				$display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
				errors++;
			end
		endfunction
	endclass

	lru_scoreboard board;
	int burst_left;
	bit [31:0] keys[8];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50_000_000;
		$display("[lru_cache_evictor_with_byte_budget] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_word);
		if (arst_n && in_valid && in_ready) board.note_input(in_word);
	end

	// receiver stall pattern
	always @(negedge clk) begin
		int phase;
		phase = int'(($time / 2000) % 3);
		if (phase == 0) out_ready <= 1'b1;
		else if (phase == 1) out_ready <= ($urandom_range(0, 3) != 0);
		else out_ready <= ($urandom_range(0, 1) != 0);
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.lim_entries = (addr == ADDR_MAX_ENTRIES) ? data[4:0] : board.lim_entries;
		board.lim_bytes = (addr == ADDR_MAX_BYTES) ? data : board.lim_bytes;
	endtask

	task automatic send(input op_t op, input logic [31:0] key, input logic [31:0] size,
		input logic pin);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_word <= '{opcode: op, key: key, size_bytes: size, pin: pin};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		int r;
		bit [31:0] sz;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: sz = $urandom();
				1: sz = $urandom_range(0, 4096);
				2: sz = 32'hFFFF_FFFF - $urandom_range(0, 3);
				default: sz = $urandom_range(0, 255);
			endcase
			if (r < 60)
				send(OP_ACCESS, keys[$urandom_range(0, 7)] + $urandom_range(0, 2), sz,
					$urandom_range(0, 5) == 0);
			else if (r < 75)
				send(OP_REMOVE, keys[$urandom_range(0, 7)], $urandom(), 1'($urandom()));
			else if (r < 90)
				send(OP_PIN, keys[$urandom_range(0, 7)], $urandom(), 1'($urandom()));
			else if (r < 93) send(OP_CLEAR, $urandom(), $urandom(), 1'($urandom()));
			else send(OP_ACCESS, $urandom(), sz, 1'($urandom()));
		end
	endtask

	initial begin
		board = new();
		board.reset_state();
		burst_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (keys[i]) keys[i] = $urandom();
		keys[0] = 32'h0;
		keys[1] = 32'hFFFF_FFFF;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: no limits, full table, extremes, every op
		send(OP_REMOVE, 32'h1234, 0, 0);
		send(OP_PIN, 32'h1234, 0, 1);
		for (int i = 0; i < 17; i++)
			send(OP_ACCESS, 32'h100 + i, (i == 0) ? 32'hFFFF_FFFF : i, i == 3);
		send(OP_ACCESS, 32'h100, 5, 0);
		send(OP_PIN, 32'h103, 0, 0);
		send(OP_REMOVE, 32'h101, 0, 0);
		send(OP_CLEAR, 0, 0, 0);
		drain();
		// count limit with pinned oldest
		write_reg(ADDR_MAX_ENTRIES, 32'd2);
		send(OP_ACCESS, 32'hFFFF_FFFF, 10, 1);
		send(OP_ACCESS, 32'h0, 20, 0);
		send(OP_ACCESS, 32'h5, 30, 0);
		send(OP_PIN, 32'hFFFF_FFFF, 0, 0);
		send(OP_ACCESS, 32'h6, 40, 0);
		drain();
		write_reg(ADDR_MAX_ENTRIES, 32'd16);
		write_reg(ADDR_MAX_BYTES, 32'd100);
		send(OP_ACCESS, 32'h7, 32'hFFFF_FFFF, 0);
		send(OP_CLEAR, 0, 0, 0);
		drain();

		write_reg(ADDR_MAX_ENTRIES, 32'd0);
		write_reg(ADDR_MAX_BYTES, 32'd0);
		random_phase(80);
		drain();
		write_reg(ADDR_MAX_ENTRIES, 32'd4);
		random_phase(80);
		drain();
		write_reg(ADDR_MAX_ENTRIES, 32'd1);
		write_reg(ADDR_MAX_BYTES, 32'd5000);
		random_phase(80);
		drain();
		write_reg(ADDR_MAX_ENTRIES, 32'd31);
		write_reg(ADDR_MAX_BYTES, 32'hFFFF_FFFF);
		random_phase(80);
		drain();
		write_reg(ADDR_MAX_ENTRIES, 32'd0);
		write_reg(ADDR_MAX_BYTES, 32'd1);
		random_phase(60);
		drain();
		write_reg(ADDR_MAX_ENTRIES, 32'd8);
		write_reg(ADDR_MAX_BYTES, 32'h8000_0000);
		random_phase(60);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("[lru_cache_evictor_with_byte_budget] OK");
		else
			$display("[lru_cache_evictor_with_byte_budget] ERROR");
		$finish;
	end
endmodule
